// ----- sv/pws_pkg.sv -----
// ---------------------------------------------------------------------------
// pws_pkg
// Shared constants, operation codes and directory interface types for the
// paged word store.
// ---------------------------------------------------------------------------
package pws_pkg;

	// fixed field widths of the ports
	localparam int ADDR_BITS    = 12;
	localparam int CFG_BITS     = 13;
	localparam int DATA_BITS    = 32;

	// widest frame index and page tag the directory structs carry
	localparam int FRM_MAX_BITS = 4;
	localparam int TAG_MAX_BITS = 8;

	// operation codes
	localparam logic [1:0] FN_PRELOAD = 2'd0;
	localparam logic [1:0] FN_READ    = 2'd1;
	localparam logic [1:0] FN_WRITE   = 2'd2;
	localparam logic [1:0] FN_FLUSH   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FILL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// sequencer to directory
	typedef struct packed {
		logic [TAG_MAX_BITS-1:0] look_tag;
		logic                    install;
		logic [FRM_MAX_BITS-1:0] inst_frame;
		logic [TAG_MAX_BITS-1:0] inst_tag;
		logic                    advance;
		logic [FRM_MAX_BITS-1:0] qry_frame;
	} pws_dir_req_t;

	// directory to sequencer
	typedef struct packed {
		logic                    hit;
		logic [FRM_MAX_BITS-1:0] hit_frame;
		logic [FRM_MAX_BITS-1:0] vict_next;
		logic                    qry_valid;
		logic [TAG_MAX_BITS-1:0] qry_tag;
	} pws_dir_rsp_t;

endpackage

// ----- sv/pws_ram.sv -----
// ---------------------------------------------------------------------------
// pws_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ---------------------------------------------------------------------------
module pws_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/pws_dir.sv -----
// ---------------------------------------------------------------------------
// pws_dir
// Frame directory: page tags, valid bits and the round-robin victim
// pointer, with a parallel tag match and an indexed tag query.
// ---------------------------------------------------------------------------
module pws_dir import pws_pkg::*; #(
	parameter int FRAMES = 6,
	parameter int TAG_W  = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  pws_dir_req_t req,
	output pws_dir_rsp_t rsp
);

	localparam int FB = $clog2(FRAMES);

	logic [TAG_W-1:0]  tag_q [FRAMES];
	logic [FRAMES-1:0] valid_q;
	logic [FB-1:0]     ptr_q;
	logic [FRAMES-1:0] match;
	logic [FB-1:0]     hit_idx;
	logic [FB-1:0]     vict_next;
	logic [FB-1:0]     qry_idx;
	logic [FB-1:0]     inst_idx;

	// tag compare against every valid frame
	always_comb begin
		hit_idx = '0;
		for (int f = FRAMES - 1; f >= 0; f--) begin
			match[f] = valid_q[f] && (tag_q[f] == TAG_W'(req.look_tag));
			if (match[f]) begin
				hit_idx = FB'(f);
			end
		end
	end

	// round-robin successor, wrapping after the last frame
	assign vict_next = (ptr_q == FB'(FRAMES - 1)) ? '0 : ptr_q + FB'(1);
	assign qry_idx   = FB'(req.qry_frame);
	assign inst_idx  = FB'(req.inst_frame);

	// responses
	always_comb begin
		rsp.hit       = |match;
		rsp.hit_frame = FRM_MAX_BITS'(hit_idx);
		rsp.vict_next = FRM_MAX_BITS'(vict_next);
		rsp.qry_valid = valid_q[qry_idx];
		rsp.qry_tag   = TAG_MAX_BITS'(tag_q[qry_idx]);
	end

	// directory state; the pointer moves only when the lookup misses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < FRAMES; f++) begin
				tag_q[f] <= '0;
			end
			valid_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (req.install) begin
				tag_q[inst_idx]   <= TAG_W'(req.inst_tag);
				valid_q[inst_idx] <= 1'b1;
			end
			if (req.advance && !(|match)) begin
				ptr_q <= vict_next;
			end
		end
	end

`ifndef SYNTHESIS
	// a page is resident in at most one frame
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("page tag matches more than one valid frame");
`endif

endmodule

// ----- sv/paged_word_store_fifo_frames_top.sv -----
// ---------------------------------------------------------------------------
// paged_word_store_fifo_frames_top
// Word store behind FRAMES page frames of PAGE_WORDS words in front of a
// backing memory, fully associative with round-robin replacement.
//
//   channel   handshake            payload
//   command   start / busy         func, address, write_data
//   result    done (one cycle)     read_data, status
//   config    words_in_use_we      words_in_use
//
// Preload, out-of-range access and hit write finish from the lookup; a hit read
// adds a read stage. A miss fills the page, first writing back the victim when
// it is valid, then does the access (and a read stage on a read).
// A flush walks every frame and writes back each valid one.
// The page copies run one word a cycle through the single read port of
// each memory. Reset clears the directory at once; the memories need no
// clearing pass. The result port cannot stall; busy holds off commands.
// PAGE_WORDS must be a power of two; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module paged_word_store_fifo_frames_top import pws_pkg::*; #(
	parameter int FRAMES        = 6,
	parameter int PAGE_WORDS    = 256,
	parameter int BACKING_WORDS = 4096,
	parameter int WORD_BITS     = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [ADDR_BITS-1:0]        address,
	input  logic signed [DATA_BITS-1:0] write_data,
	output logic                        done,
	output logic signed [DATA_BITS-1:0] read_data,
	output logic [1:0]                  status,
	input  logic                        words_in_use_we,
	input  logic [CFG_BITS-1:0]         words_in_use
);

	localparam int FB     = $clog2(FRAMES);
	localparam int OB     = $clog2(PAGE_WORDS);
	localparam int TAG_W  = ADDR_BITS - OB;
	localparam int FA_W   = FB + OB;
	localparam int FDEPTH = FRAMES * PAGE_WORDS;
	localparam int BA_W   = $clog2(BACKING_WORDS);
	localparam int CNT_W  = OB + 1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOOK  = 7'b0000010,
		S_FLUSH = 7'b0000100,
		S_WB    = 7'b0001000,
		S_FILL  = 7'b0010000,
		S_ACC   = 7'b0100000,
		S_RD    = 7'b1000000
	} pws_state_t;

	pws_state_t state_q, state_d;

	// control registers
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 copy_vld_s1;
	logic [FB-1:0]        fi_q;
	logic                 fill_q;
	logic                 wb_flush_q;
	logic [FB-1:0]        vict_q;
	logic [FB-1:0]        wb_frame_q;
	logic [TAG_W-1:0]     wb_page_q;
	logic [CFG_BITS-1:0]  words_in_use_q;

	// payload registers
	logic [1:0]           func_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [WORD_BITS-1:0] data_q;
	logic [ADDR_BITS-1:0] copy_addr_s1;
	logic                 copy_inr_s1;
	logic [DATA_BITS-1:0] read_data_q;
	logic [1:0]           status_q;

	// decode
	logic [TAG_W-1:0]     page;
	logic [OB-1:0]        off;
	logic                 pre_oor;
	logic                 acc_oor;
	logic                 is_read;
	logic                 cnt_done;
	logic                 copy_issue;
	logic [OB-1:0]        copy_off;
	logic [TAG_W-1:0]     copy_page;
	logic [ADDR_BITS-1:0] copy_addr;
	logic                 copy_inr;

	// directory
	pws_dir_req_t         dreq;
	pws_dir_rsp_t         drsp;
	logic [FB-1:0]        hit_frame;
	logic [FB-1:0]        vict_next;
	logic [FB-1:0]        vict_succ;
	logic [TAG_W-1:0]     qry_tag;

	// sequencer outputs
	logic                 emit;
	logic [1:0]           emit_st;
	logic                 emit_rd;

	// memory ports
	logic                 f_we, f_re;
	logic [FA_W-1:0]      f_waddr, f_raddr;
	logic [WORD_BITS-1:0] f_wdata, f_rdata;
	logic                 b_we, b_re;
	logic [BA_W-1:0]      b_waddr, b_raddr;
	logic [WORD_BITS-1:0] b_wdata, b_rdata;

	// address split and range checks
	assign page     = addr_q[ADDR_BITS-1 -: TAG_W];
	assign off      = addr_q[OB-1:0];
	assign pre_oor  = 32'(addr_q) >= 32'(BACKING_WORDS);
	assign acc_oor  = pre_oor || ({1'b0, addr_q} >= words_in_use_q);
	assign is_read  = func_q == FN_READ;

	// page copy counter and source address
	assign cnt_done   = cnt_q == CNT_W'(PAGE_WORDS);
	assign copy_issue = (state_q == S_WB || state_q == S_FILL) && !cnt_done;
	assign copy_off   = cnt_q[OB-1:0];
	assign copy_page  = (state_q == S_WB) ? wb_page_q : page;
	assign copy_addr  = {copy_page, copy_off};
	assign copy_inr   = 32'(copy_addr) < 32'(BACKING_WORDS);

	// next victim, tracked from the last victim taken
	assign vict_succ = (vict_q == FB'(FRAMES - 1)) ? '0 : vict_q + FB'(1);

	// directory requests; the directory gates advance with its own miss
	always_comb begin
		dreq.look_tag   = TAG_MAX_BITS'(page);
		dreq.install    = state_q == S_FILL && cnt_done;
		dreq.inst_frame = FRM_MAX_BITS'(vict_q);
		dreq.inst_tag   = TAG_MAX_BITS'(page);
		dreq.advance    = state_q == S_LOOK && func_q != FN_PRELOAD && func_q != FN_FLUSH
			&& !acc_oor;
		dreq.qry_frame  = (state_q == S_FLUSH) ? FRM_MAX_BITS'(fi_q)
			: FRM_MAX_BITS'(vict_succ);
	end

	assign hit_frame = FB'(drsp.hit_frame);
	assign vict_next = FB'(drsp.vict_next);
	assign qry_tag   = TAG_W'(drsp.qry_tag);

	pws_dir #(
		.FRAMES (FRAMES),
		.TAG_W  (TAG_W)
	) u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		emit_st = ST_DONE;
		emit_rd = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				priority if (func_q == FN_PRELOAD) begin
					emit    = 1'b1;
					emit_st = pre_oor ? ST_RANGE : ST_DONE;
					state_d = S_IDLE;
				end else if (func_q == FN_FLUSH) begin
					state_d = S_FLUSH;
				end else if (acc_oor) begin
					emit    = 1'b1;
					emit_st = ST_RANGE;
					state_d = S_IDLE;
				end else if (drsp.hit) begin
					if (is_read) begin
						state_d = S_RD;
					end else begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = drsp.qry_valid ? S_WB : S_FILL;
				end
			end
			S_FLUSH: begin
				if (drsp.qry_valid) begin
					state_d = S_WB;
				end else if (fi_q == FB'(FRAMES - 1)) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WB: begin
				if (cnt_done) begin
					if (!wb_flush_q) begin
						state_d = S_FILL;
					end else if (wb_frame_q == FB'(FRAMES - 1)) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_FILL: begin
				if (cnt_done) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				if (is_read) begin
					state_d = S_RD;
				end else begin
					emit    = 1'b1;
					emit_st = ST_FILL;
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				emit    = 1'b1;
				emit_st = fill_q ? ST_FILL : ST_DONE;
				emit_rd = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// frame memory access
	always_comb begin
		f_we    = 1'b0;
		f_waddr = {vict_q, off};
		f_wdata = data_q;
		f_re    = 1'b0;
		f_raddr = {vict_q, off};
		unique case (state_q)
			S_LOOK: begin
				f_waddr = {hit_frame, off};
				f_raddr = {hit_frame, off};
				if (func_q == FN_PRELOAD) begin
					f_we = !pre_oor && drsp.hit;
				end else if (func_q != FN_FLUSH && !acc_oor && drsp.hit) begin
					f_we = !is_read;
					f_re = is_read;
				end
			end
			S_WB: begin
				f_re    = copy_issue;
				f_raddr = {wb_frame_q, copy_off};
			end
			S_FILL: begin
				f_we    = copy_vld_s1;
				f_waddr = {vict_q, copy_addr_s1[OB-1:0]};
				f_wdata = copy_inr_s1 ? b_rdata : '0;
			end
			S_ACC: begin
				f_we = !is_read;
				f_re = is_read;
			end
			default: begin
			end
		endcase
	end

	// backing memory access
	always_comb begin
		b_we    = 1'b0;
		b_waddr = BA_W'(addr_q);
		b_wdata = data_q;
		b_re    = 1'b0;
		b_raddr = BA_W'(copy_addr);
		unique case (state_q)
			S_LOOK: begin
				b_we = func_q == FN_PRELOAD && !pre_oor;
			end
			S_WB: begin
				b_we    = copy_vld_s1 && copy_inr_s1;
				b_waddr = BA_W'(copy_addr_s1);
				b_wdata = f_rdata;
			end
			S_FILL: begin
				b_re = copy_issue && copy_inr;
			end
			default: begin
			end
		endcase
	end

	pws_ram #(
		.DEPTH (FDEPTH),
		.AW    (FA_W),
		.DW    (WORD_BITS)
	) u_frame_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	pws_ram #(
		.DEPTH (BACKING_WORDS),
		.AW    (BA_W),
		.DW    (WORD_BITS)
	) u_backing_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			done_q         <= 1'b0;
			cnt_q          <= '0;
			copy_vld_s1    <= 1'b0;
			fi_q           <= '0;
			fill_q         <= 1'b0;
			wb_flush_q     <= 1'b0;
			vict_q         <= '0;
			wb_frame_q     <= '0;
			wb_page_q      <= '0;
			words_in_use_q <= '0;
		end else begin
			state_q     <= state_d;
			done_q      <= emit;
			copy_vld_s1 <= copy_issue;
			if (words_in_use_we) begin
				words_in_use_q <= words_in_use;
			end
			// copy counter restarts on entry to a page copy
			if ((state_d == S_WB || state_d == S_FILL) && state_d != state_q) begin
				cnt_q <= '0;
			end else if (copy_issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			unique case (state_q)
				S_LOOK: begin
					fill_q <= 1'b0;
					fi_q   <= '0;
					if (dreq.advance && !drsp.hit) begin
						vict_q     <= vict_next;
						wb_frame_q <= vict_next;
						wb_page_q  <= qry_tag;
						wb_flush_q <= 1'b0;
					end
				end
				S_FLUSH: begin
					if (drsp.qry_valid) begin
						wb_frame_q <= fi_q;
						wb_page_q  <= qry_tag;
						wb_flush_q <= 1'b1;
					end else if (fi_q != FB'(FRAMES - 1)) begin
						fi_q <= fi_q + FB'(1);
					end
				end
				S_WB: begin
					if (cnt_done && wb_flush_q && wb_frame_q != FB'(FRAMES - 1)) begin
						fi_q <= fi_q + FB'(1);
					end
				end
				S_FILL: begin
					if (cnt_done) begin
						fill_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// command capture, copy stage and result beat
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			func_q <= func;
			addr_q <= address;
			data_q <= WORD_BITS'(write_data);
		end
		copy_addr_s1 <= copy_addr;
		copy_inr_s1  <= copy_inr;
		status_q     <= emit_st;
		read_data_q  <= emit_rd ? DATA_BITS'($signed(f_rdata)) : '0;
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign read_data = read_data_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	// an out-of-range beat never carries data
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_RANGE) |-> (read_data_q == '0))
		else $error("out-of-range result with nonzero data");

	// the copy stage only drains inside a page copy
	a_copy_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> (state_q == S_WB || state_q == S_FILL))
		else $error("copy stage active outside a page copy");

	// the copy counter never passes the page length
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB || state_q == S_FILL) |-> (cnt_q <= CNT_W'(PAGE_WORDS)))
		else $error("page copy counter overran");
`endif

endmodule
